@@ rtl/cgq_pkg.sv @@
// Shared types and constants for the contact graph query block.
package cgq_pkg;

  localparam int MaxPeople = 64;
  localparam int IdxW      = $clog2(MaxPeople);
  localparam int CntW      = IdxW + 1;

  localparam logic [CntW-1:0] CntReset = CntW'(MaxPeople);

  // Word kinds on the input channel
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result codes
  localparam logic [1:0] OUT_DIRECT   = 2'd0;
  localparam logic [1:0] OUT_INDIRECT = 2'd1;
  localparam logic [1:0] OUT_NONE     = 2'd2;

  typedef logic [MaxPeople-1:0] row_t;
  typedef logic [IdxW-1:0]      idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRA,
    S_WRB,
    S_EVAL,
    S_ENC
  } cgq_state_t;

  typedef struct packed {
    logic cap;
    logic wr_a;
    logic wr_b;
    logic eval;
    logic out_load;
  } cgq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } cgq_sts_t;

endpackage

@@ rtl/cgq_ctrl.sv @@
// Sequencer for loads and queries of the contact graph query block.
module cgq_ctrl import cgq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_mode,
  output logic     in_tready,
  input  cgq_sts_t sts,
  output cgq_cmd_t cmd
);

  cgq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = (in_mode == MODE_LOAD) ? S_WRA : S_EVAL;
        end
      end
      S_WRA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_ENC;
      end
      S_ENC: begin
        // hold the result until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/cgq_datapath.sv @@
// Contact matrix memory, query evaluation and output register.
module cgq_datapath import cgq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cgq_cmd_t        cmd,
  output cgq_sts_t        sts,
  input  idx_t            in_a,
  input  idx_t            in_b,
  input  logic            in_bit,
  input  logic            cfg_wr_en,
  input  logic [CntW-1:0] cfg_wr_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [1:0]      out_outcome,
  output idx_t            out_via
);

  row_t               mem [MaxPeople];
  logic [MaxPeople-1:0] row_vld_r;

  logic [CntW-1:0] cnt_r;
  idx_t            a_r, b_r;
  logic            bit_r;
  row_t            ra_r, rb_r;
  logic            va_r, vb_r;

  logic            none_r, direct_r;
  row_t            common_r;

  logic            out_vld_r;
  logic [1:0]      outcome_r;
  idx_t            via_r;

  row_t            row_a, row_b, row_hi;
  idx_t            hi, lo;
  logic [CntW-1:0] eff_cnt;
  row_t            common_nxt;
  logic            wr_en;
  idx_t            wr_addr;
  row_t            wr_row;
  logic [1:0]      outcome_nxt;
  idx_t            via_nxt;

  // rows never written read as zero
  assign row_a   = va_r ? ra_r : '0;
  assign row_b   = vb_r ? rb_r : '0;
  assign hi      = (a_r > b_r) ? a_r : b_r;
  assign lo      = (a_r > b_r) ? b_r : a_r;
  assign row_hi  = (a_r > b_r) ? row_a : row_b;
  assign eff_cnt = (cnt_r > CntW'(MaxPeople)) ? CntW'(MaxPeople) : cnt_r;

  always_comb begin
    for (int i = 0; i < MaxPeople; i++) begin
      common_nxt[i] = row_a[i] & row_b[i] & (CntW'(i) < eff_cnt) &
                      (IdxW'(i) != hi) & (IdxW'(i) != lo);
    end
  end

  always_comb begin
    wr_en   = cmd.wr_a | cmd.wr_b;
    wr_addr = cmd.wr_a ? a_r : b_r;
    wr_row  = cmd.wr_a ? row_a : row_b;
    wr_row[cmd.wr_a ? b_r : a_r] = bit_r;
  end

  always_comb begin
    via_nxt = '0;
    for (int i = MaxPeople - 1; i >= 0; i--) begin
      if (common_r[i]) begin
        via_nxt = IdxW'(i);
      end
    end
    priority if (none_r) begin
      outcome_nxt = OUT_NONE;
      via_nxt     = '0;
    end else if (direct_r) begin
      outcome_nxt = OUT_DIRECT;
      via_nxt     = '0;
    end else if (common_r != '0) begin
      outcome_nxt = OUT_INDIRECT;
    end else begin
      outcome_nxt = OUT_NONE;
      via_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ra_r <= mem[in_a];
      rb_r <= mem[in_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      a_r   <= in_a;
      b_r   <= in_b;
      bit_r <= in_bit;
      va_r  <= row_vld_r[in_a];
      vb_r  <= row_vld_r[in_b];
    end
    if (cmd.eval) begin
      none_r   <= {1'b0, hi} >= eff_cnt;
      direct_r <= row_hi[lo];
      common_r <= common_nxt;
    end
    if (cmd.out_load) begin
      outcome_r <= outcome_nxt;
      via_r     <= via_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      cnt_r     <= CntReset;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_vld_r & ~out_tready;
  assign out_tvalid   = out_vld_r;
  assign out_outcome  = outcome_r;
  assign out_via      = via_r;

endmodule

@@ rtl/contact_graph_query.sv @@
// Contact graph query: a symmetric 64-person contact matrix held in a memory with one write
// and two read ports. A load word (tuser 0) stores one contact bit at both mirrored places and
// gives no result; it reads both rows, then writes one row at a time through the single write
// port. A query word (tuser 1) gives one result word after a row read, an evaluate step and a
// priority encode, later if the previous result has not yet been taken. One word is in flight
// at a time. Rows read as zero until first written, so no clearing pass is needed.
module contact_graph_query import cgq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // person_a[5:0], person_b[11:6], contact_bit[12], zeros
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // outcome[1:0], via_person[7:2]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data // people_count
);

  cgq_cmd_t   cmd;
  cgq_sts_t   sts;
  logic [1:0] outcome;
  idx_t       via;

  cgq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_a        (in_tdata[5:0]),
    .in_b        (in_tdata[11:6]),
    .in_bit      (in_tdata[12]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_outcome (outcome),
    .out_via     (via)
  );

  assign out_tdata = {via, outcome};

endmodule

@@ rtl/cgq_checker.sv @@
// Port-level checks for the contact graph query block, bound to the top level.
module cgq_checker import cgq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("illegal outcome code");

  a_via_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != OUT_INDIRECT |-> out_tdata[7:2] == '0)
    else $error("via person set without indirect contact");

  // a load occupies the write port through both row writes
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_LOAD |=> !in_tready ##1 !in_tready)
    else $error("word accepted during row writes");

endmodule

bind contact_graph_query cgq_checker u_cgq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
